// ===== sv/clc_pkg.sv =====
package clc_pkg;

    localparam int MAX_DIGITS = 19;
    localparam int NUM_W      = 63;
    localparam int SUM_W      = 8;
    localparam int CNT_W      = 5;

    // Reciprocal of ten for numbers below 2**63: q = (n * RECIP) >> RECIP_SHIFT.
    localparam logic [31:0] RECIP_HI    = 32'h6666_6666;
    localparam logic [31:0] RECIP_LO    = 32'h6666_6667;
    localparam int          RECIP_SHIFT = 66;

    typedef enum logic [1:0] {
        KIND_INVALID = 2'd0,
        KIND_FIFTEEN = 2'd1,
        KIND_SIXTEEN = 2'd2,
        KIND_LEAD4   = 2'd3
    } card_kind_t;

    // Payload carried between digit stages.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [SUM_W-1:0] sum;
        logic [CNT_W-1:0] cnt;
        logic [3:0]       top;
        logic [3:0]       second;
        logic             alt;
    } digit_state_t;

    // Luhn contribution of one digit, doubled or not.
    function automatic logic [3:0] luhn_term(input logic [3:0] d, input logic dbl);
        logic [4:0] p;
        p = {d, 1'b0};
        if (!dbl) begin
            return d;
        end
        if (p >= 5'd10) begin
            return 4'(p - 5'd9);
        end
        return p[3:0];
    endfunction

endpackage

// ===== sv/clc_digit_stage.sv =====
// One pipeline stage: peel one decimal digit off the number.
// Two register levels: the first holds the partial products of the
// reciprocal multiply by one tenth, the second the updated digit state.
module clc_digit_stage (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  clc_pkg::digit_state_t in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output clc_pkg::digit_state_t out_data
);

    logic                      p_valid_reg;
    clc_pkg::digit_state_t     p_data_reg;
    logic [63:0]               p_ll_reg;
    logic [63:0]               p_lh_reg;
    logic [63:0]               p_hl_reg;
    logic [63:0]               p_hh_reg;
    logic [63:0]               p_ll_next;
    logic [63:0]               p_lh_next;
    logic [63:0]               p_hl_next;
    logic [63:0]               p_hh_next;
    logic                      p_ready;
    logic [64:0]               p_mid;
    logic [127:0]              product;
    logic [clc_pkg::NUM_W-1:0] quot;
    logic [7:0]                quot_x10;
    logic [3:0]                digit;
    logic                      active;
    logic                      valid_reg;
    clc_pkg::digit_state_t     data_reg;
    clc_pkg::digit_state_t     data_next;

    // Four 32x32 partial products of number and reciprocal.
    assign p_ll_next = 64'(in_data.num[31:0]) * 64'(clc_pkg::RECIP_LO);
    assign p_lh_next = 64'(in_data.num[31:0]) * 64'(clc_pkg::RECIP_HI);
    assign p_hl_next = 64'(in_data.num[clc_pkg::NUM_W-1:32]) * 64'(clc_pkg::RECIP_LO);
    assign p_hh_next = 64'(in_data.num[clc_pkg::NUM_W-1:32]) * 64'(clc_pkg::RECIP_HI);

    // Combine the partial products; the quotient is the top of the sum.
    assign p_mid    = 65'(p_lh_reg) + 65'(p_hl_reg);
    assign product  = {p_hh_reg, p_ll_reg} + (128'(p_mid) << 32);
    assign quot     = clc_pkg::NUM_W'(product[127:clc_pkg::RECIP_SHIFT]);
    // The remainder is below ten, so the low four bits settle it.
    assign quot_x10 = 8'(quot[3:0]) * 8'd10;
    assign digit    = p_data_reg.num[3:0] - quot_x10[3:0];
    assign active   = (p_data_reg.num != '0) &&
                      (p_data_reg.cnt < clc_pkg::CNT_W'(clc_pkg::MAX_DIGITS));

    always_comb begin
        data_next = p_data_reg;
        if (active) begin
            data_next.num    = quot;
            data_next.sum    = p_data_reg.sum +
                               clc_pkg::SUM_W'(clc_pkg::luhn_term(digit, p_data_reg.alt));
            data_next.cnt    = p_data_reg.cnt + 1'b1;
            data_next.second = p_data_reg.top;
            data_next.top    = digit;
            data_next.alt    = !p_data_reg.alt;
        end
    end

    assign p_ready   = !valid_reg || out_ready;
    assign in_ready  = !p_valid_reg || p_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (in_ready) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            p_data_reg <= in_data;
            p_ll_reg   <= p_ll_next;
            p_lh_reg   <= p_lh_next;
            p_hl_reg   <= p_hl_next;
            p_hh_reg   <= p_hh_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (p_ready) begin
            valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && p_valid_reg) begin
            data_reg <= data_next;
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> data_reg.cnt <= clc_pkg::CNT_W'(clc_pkg::MAX_DIGITS))
        else $error("digit count beyond limit");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled stage changed");
    a_sum_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> data_reg.sum <= 8'd171)
        else $error("luhn sum out of range");

endmodule

// ===== sv/card_number_luhn_classify_core.sv =====
// Luhn mod-10 check and kind classification of a binary card number.
// Each word on s_axis is one number; it passes through a chain of 19 digit
// stages and a final classify stage. Each digit stage peels one decimal
// digit by a reciprocal multiply by one tenth and is two registers deep
// (partial products, then digit state), so the chain holds 39 registers
// between s_axis and the result word on m_axis. A new word is accepted
// every cycle while m_axis is not stalled; results come out in order, one per
// input word, and a stall on m_axis backs up the chain without loss.
module card_number_luhn_classify_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [62:0] card_number, [63] zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [1:0] card_kind, [9:2] luhn_sum,
                                        // [14:10] digit_count, [15] zero
);

    localparam int N = clc_pkg::MAX_DIGITS;

    logic                  v   [N+1];
    logic                  r   [N+1];
    clc_pkg::digit_state_t d   [N+1];

    // Seed the chain with the raw number and empty accumulators.
    assign v[0]          = s_axis_tvalid;
    assign s_axis_tready = r[0];
    assign d[0]          = {s_axis_tdata[clc_pkg::NUM_W-1:0],
                            {($bits(clc_pkg::digit_state_t) - clc_pkg::NUM_W){1'b0}}};

    for (genvar i = 0; i < N; i++) begin : g_stage
        clc_digit_stage u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v[i]),
            .in_ready  (r[i]),
            .in_data   (d[i]),
            .out_valid (v[i+1]),
            .out_ready (r[i+1]),
            .out_data  (d[i+1])
        );
    end

    // Classify stage.
    logic              valid_reg;
    logic [15:0]       tdata_reg;
    logic [15:0]       tdata_next;
    clc_pkg::card_kind_t kind;
    logic [6:0]        prefix;
    logic [15:0]       sum_scaled;
    logic [4:0]        sum_quot;
    logic [7:0]        sum_mod;

    assign prefix     = 7'(d[N].top) * 7'd10 + 7'(d[N].second);
    // Sum stays below 1029, where multiply by 205 and shift by 11 divides by ten.
    assign sum_scaled = 16'(d[N].sum) * 16'd205;
    assign sum_quot   = sum_scaled[15:11];
    assign sum_mod    = d[N].sum - 8'(sum_quot) * 8'd10;

    always_comb begin
        kind = clc_pkg::KIND_INVALID;
        if (d[N].num == '0 && sum_mod == 8'd0) begin
            priority if (d[N].cnt == 5'd15 && (prefix == 7'd34 || prefix == 7'd37)) begin
                kind = clc_pkg::KIND_FIFTEEN;
            end else if (d[N].cnt == 5'd16 && prefix > 7'd50 && prefix < 7'd56) begin
                kind = clc_pkg::KIND_SIXTEEN;
            end else if ((d[N].cnt == 5'd13 || d[N].cnt == 5'd16) && d[N].top == 4'd4) begin
                kind = clc_pkg::KIND_LEAD4;
            end
        end
        tdata_next = {1'b0, d[N].cnt, d[N].sum, kind};
    end

    assign r[N]          = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = tdata_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (r[N]) begin
            valid_reg <= v[N];
        end
    end

    always_ff @(posedge aclk) begin
        if (r[N] && v[N]) begin
            tdata_reg <= tdata_next;
        end
    end

    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> tdata_reg[15] == 1'b0)
        else $error("pad bit set");
    a_kind_len: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && tdata_reg[1:0] != 2'd0 |-> tdata_reg[14:10] >= 5'd13)
        else $error("valid kind with short number");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule
